@@ rtl/core/compact_target_retarget_core_defines.svh @@
// Assertion macros used by the retarget core top level.
`ifndef COMPACT_TARGET_RETARGET_CORE_DEFINES_SVH
`define COMPACT_TARGET_RETARGET_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/crt_pkg.sv @@
// Package with shared types and constants of the compact target retarget core.
`default_nettype none
package crt_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CRT_REG_INTERVAL = 2'd0;
  localparam logic [1:0] CRT_REG_SECONDS  = 2'd1;
  localparam logic [1:0] CRT_REG_GENESIS  = 2'd2;

  localparam logic [15:0] CRT_INTERVAL_RST = 16'd2016;
  localparam logic [15:0] CRT_SECONDS_RST  = 16'd600;
  localparam logic [31:0] CRT_GENESIS_RST  = 32'h1D00FFFF;

  localparam int unsigned CRT_PW    = 58;  // mantissa times elapsed time
  localparam int unsigned CRT_DW    = 32;  // depth bits
  // P bits plus enough zero steps to collect 32 significant quotient bits
  localparam int unsigned CRT_CELLS = 122;

  // Work item handed from cell to cell
  typedef struct packed {
    logic                vld;
    logic [31:0]         prev;     // previous compact target
    logic                flt;      // exponent below three or zero ideal time
    logic [CRT_PW-1:0]   pbits;    // dividend bits still to shift in
    logic [5:0]          pcnt;
    logic [10:0]         zcnt;     // trailing zero bits not yet shifted in
    logic [31:0]         rem;
    logic [CRT_PW-1:0]   quot;
    logic [CRT_DW-1:0]   dbits;    // depth+1 bits for the interval check
    logic [5:0]          dcnt;
    logic [15:0]         drem;
  } crt_cell_t;

  // Finish stage to output stage
  typedef struct packed {
    logic              vld;
    logic [31:0]       prev;
    logic              retgt;
    logic              bad;
    logic [8:0]        len;
    logic [5:0]        sh;
    logic [CRT_PW-1:0] quot;
  } crt_fin_t;

endpackage
`default_nettype wire

@@ rtl/core/crt_front.sv @@
// Input stages: elapsed time, clamp and mantissa product.
`default_nettype none
module crt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              accept_i,
  input  wire logic [31:0]       prev_target_i,
  input  wire logic [31:0]       prev_depth_i,
  input  wire logic [31:0]       prev_time_i,
  input  wire logic [31:0]       start_time_i,
  input  wire logic [31:0]       ideal_i,
  output logic                   s0_vld_o,
  output crt_pkg::crt_cell_t     cell_o
);

  logic               s0_vld_q;
  logic [31:0]        prev_q;
  logic [31:0]        dep_q;
  logic signed [32:0] el_q;

  // Capture the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (accept_i) begin
      s0_vld_q <= 1'b1;
    end else if (en_i) begin
      s0_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      prev_q <= prev_target_i;
      dep_q  <= prev_depth_i + 32'd1;
      el_q   <= $signed({1'b0, prev_time_i}) - $signed({1'b0, start_time_i});
    end
  end

  // Clamp elapsed time and form the dividend
  logic signed [34:0] el_ext, lo_s, hi_s, el_cl;
  logic [33:0]        el_u;
  logic [7:0]         exp_in;
  crt_pkg::crt_cell_t cell_d, cell_q;

  always_comb begin
    el_ext = {{2{el_q[32]}}, el_q};
    lo_s   = $signed({5'd0, ideal_i[31:2]});
    hi_s   = $signed({1'b0, ideal_i, 2'b00});
    el_cl  = el_ext;
    if (el_cl < lo_s) el_cl = lo_s;
    if (el_cl > hi_s) el_cl = hi_s;
    el_u   = el_cl[33:0];
    exp_in = prev_q[31:24];

    cell_d.vld   = s0_vld_q;
    cell_d.prev  = prev_q;
    cell_d.flt   = (exp_in < 8'd3) || (ideal_i == 32'd0);
    cell_d.pbits = {10'd0, prev_q[23:0]} * {24'd0, el_u};
    cell_d.pcnt  = 6'(crt_pkg::CRT_PW);
    cell_d.zcnt  = (exp_in < 8'd3) ? 11'd0 : {exp_in - 8'd3, 3'b000};
    cell_d.rem   = '0;
    cell_d.quot  = '0;
    cell_d.dbits = dep_q;
    cell_d.dcnt  = 6'(crt_pkg::CRT_DW);
    cell_d.drem  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign s0_vld_o = s0_vld_q;
  assign cell_o   = cell_q;

endmodule
`default_nettype wire

@@ rtl/core/crt_cell.sv @@
// One division cell: up to one quotient bit and one depth remainder bit per cycle while enabled.
`default_nettype none
module crt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [31:0]        ideal_i,
  input  wire logic [15:0]        interval_i,
  input  crt_pkg::crt_cell_t      cell_i,
  output crt_pkg::crt_cell_t      cell_o
);

  crt_pkg::crt_cell_t cell_d, cell_q;
  logic               dostep, bitin, qbit;
  logic [32:0]        t;
  logic [16:0]        t2;

  always_comb begin
    cell_d = cell_i;
    dostep = 1'b0;
    bitin  = 1'b0;
    // Feed dividend bits first, then zeros until 32 quotient bits stand or zcnt runs out
    if (cell_i.pcnt != 6'd0) begin
      dostep       = 1'b1;
      bitin        = cell_i.pbits[crt_pkg::CRT_PW-1];
      cell_d.pbits = {cell_i.pbits[crt_pkg::CRT_PW-2:0], 1'b0};
      cell_d.pcnt  = cell_i.pcnt - 6'd1;
    end else if (cell_i.zcnt != 11'd0 && cell_i.quot[crt_pkg::CRT_PW-1:31] == '0) begin
      dostep      = 1'b1;
      cell_d.zcnt = cell_i.zcnt - 11'd1;
    end
    // Restoring division step
    t    = {cell_i.rem, bitin};
    qbit = (t >= {1'b0, ideal_i});
    if (dostep) begin
      cell_d.rem  = qbit ? 32'(t - {1'b0, ideal_i}) : t[31:0];
      cell_d.quot = {cell_i.quot[crt_pkg::CRT_PW-2:0], qbit};
    end
    // Depth remainder step
    t2 = {cell_i.drem, cell_i.dbits[crt_pkg::CRT_DW-1]};
    if (cell_i.dcnt != 6'd0) begin
      cell_d.drem  = (t2 >= {1'b0, interval_i}) ? 16'(t2 - {1'b0, interval_i})
                                                : t2[15:0];
      cell_d.dbits = {cell_i.dbits[crt_pkg::CRT_DW-2:0], 1'b0};
      cell_d.dcnt  = cell_i.dcnt - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

@@ rtl/core/crt_finish.sv @@
// Finish stages: byte length, mantissa extraction and genesis cap.
`default_nettype none
module crt_finish (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [15:0]        interval_i,
  input  wire logic [31:0]        genesis_i,
  input  crt_pkg::crt_cell_t      cell_i,
  output logic                    vld_o,
  output logic [31:0]             next_target_o,
  output logic                    recomputed_o,
  output logic                    fault_o
);

  crt_pkg::crt_fin_t fin_d, fin_q;
  logic [6:0]        blen;
  logic [11:0]       lbits, lsum, shw;

  // Measure the quotient and derive the byte length
  always_comb begin
    blen = '0;
    for (int i = 0; i < crt_pkg::CRT_PW; i++) begin
      if (cell_i.quot[i]) blen = 7'(i + 1);
    end
    lbits = (cell_i.quot == '0) ? 12'd0 : ({5'd0, blen} + {1'b0, cell_i.zcnt});
    lsum  = lbits + 12'd7;
    shw   = {lsum[11:3], 3'b000} - 12'd24 - {1'b0, cell_i.zcnt};

    fin_d.vld   = cell_i.vld;
    fin_d.prev  = cell_i.prev;
    fin_d.retgt = (interval_i != 16'd0) && (cell_i.drem == 16'd0);
    fin_d.len   = lsum[11:3];
    fin_d.bad   = cell_i.flt || (lsum[11:3] < 9'd4);
    fin_d.sh    = shw[5:0];
    fin_d.quot  = cell_i.quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= '0;
    end else if (en_i) begin
      fin_q <= fin_d;
    end
  end

  // Select mantissa, cap at genesis, pick the result
  logic [crt_pkg::CRT_PW-1:0] shq;
  logic [23:0]                mant;
  logic [8:0]                 gexp;
  logic [31:0]                res;
  logic                       rec, flt;

  always_comb begin
    shq  = fin_q.quot >> fin_q.sh;
    mant = shq[23:0];
    gexp = {1'b0, genesis_i[31:24]};
    res  = {fin_q.len[7:0], mant};
    if (fin_q.len > gexp || (fin_q.len == gexp && mant > genesis_i[23:0])) begin
      res = genesis_i;
    end
    rec = fin_q.retgt;
    flt = fin_q.retgt && fin_q.bad;
    if (!fin_q.retgt || fin_q.bad) res = fin_q.prev;
  end

  logic        vld_q;
  logic [31:0] nt_q;
  logic        rec_q, flt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= fin_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nt_q  <= res;
      rec_q <= rec;
      flt_q <= flt;
    end
  end

  assign vld_o         = vld_q;
  assign next_target_o = nt_q;
  assign recomputed_o  = rec_q;
  assign fault_o       = flt_q;

endmodule
`default_nettype wire

@@ rtl/core/compact_target_retarget_core.sv @@
// Top level of the compact target retarget core.
//   channel  | dir | payload
//   s_axis   | in  | tdata: prev_target, prev_depth, prev_time, start_time
//   m_axis   | out | tdata: next_target; tuser: recomputed, fault
//   cfg      | in  | write enable, register index, 32-bit data
// One transaction enters per cycle unless m_axis stalls. Results pass the input
// and product stages, 122 division cells (up to one quotient bit each), the
// finish and output stages. A stall on m_axis holds every stage; the input stage
// still fills if empty. Reset clears the valid flags and loads the register defaults.
`default_nettype none
`include "compact_target_retarget_core_defines.svh"
module compact_target_retarget_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // prev_target, prev_depth, prev_time, start_time
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // next_target
  output logic [1:0]        m_axis_tuser,  // recomputed, fault
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  logic [15:0] interval_q, seconds_q;
  logic [31:0] genesis_q, ideal_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= crt_pkg::CRT_INTERVAL_RST;
      seconds_q  <= crt_pkg::CRT_SECONDS_RST;
      genesis_q  <= crt_pkg::CRT_GENESIS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt_pkg::CRT_REG_INTERVAL: interval_q <= cfg_wdata_i[15:0];
        crt_pkg::CRT_REG_SECONDS:  seconds_q  <= cfg_wdata_i[15:0];
        crt_pkg::CRT_REG_GENESIS:  genesis_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Ideal period length
  always_ff @(posedge clk_i) begin
    ideal_q <= {16'd0, interval_q} * {16'd0, seconds_q};
  end

  logic en, accept, s0_vld;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s0_vld || en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  crt_pkg::crt_cell_t chain [crt_pkg::CRT_CELLS+1];

  crt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .prev_target_i (s_axis_tdata[31:0]),
    .prev_depth_i  (s_axis_tdata[63:32]),
    .prev_time_i   (s_axis_tdata[95:64]),
    .start_time_i  (s_axis_tdata[127:96]),
    .ideal_i       (ideal_q),
    .s0_vld_o      (s0_vld),
    .cell_o        (chain[0])
  );

  // Row of division cells
  for (genvar g = 0; g < crt_pkg::CRT_CELLS; g++) begin : g_cell
    crt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .ideal_i    (ideal_q),
      .interval_i (interval_q),
      .cell_i     (chain[g]),
      .cell_o     (chain[g+1])
    );
  end

  crt_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .interval_i    (interval_q),
    .genesis_i     (genesis_q),
    .cell_i        (chain[crt_pkg::CRT_CELLS]),
    .vld_o         (m_axis_tvalid),
    .next_target_o (m_axis_tdata),
    .recomputed_o  (m_axis_tuser[0]),
    .fault_o       (m_axis_tuser[1])
  );

  `CRT_ASSERT_IMPL(a_fault_needs_recompute, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "fault without recompute")
  `CRT_ASSERT_IMPL(a_genesis_cap, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1], m_axis_tdata[31:24] <= genesis_q[31:24], "result above genesis exponent")
  `CRT_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

endmodule
`default_nettype wire
